// File: rtl/gpor_pkg.sv
// ---------------------------------------------------------------------------
// gpor_pkg: shared types and constants
// widths, stage counts and the per-axis parameter record for the owner block
// ---------------------------------------------------------------------------
package gpor_pkg;

    localparam int FRAC_BITS      = 24;
    localparam int MAX_PROCS_AXIS = 256;
    localparam int NUM_AXES       = 3;

    localparam int COORD_W  = 24;
    localparam int COARSE_W = 11;
    localparam int PROCS_W  = 9;
    localparam int REFINE_W = 4;
    localparam int NODE_W   = 8;
    localparam int RANK_W   = 24;

    // fine index and divisor width: 2047 * 15 fits in 15 bits
    localparam int IDX_W    = 15;
    localparam int RCP_W    = IDX_W + 1;
    localparam int PROD_W   = FRAC_BITS + IDX_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // pipeline layout: axis stages, then two rank stages, then the output register
    localparam int AXIS_STAGES = 7;
    localparam int NUM_STAGES  = AXIS_STAGES + 3;

    localparam logic [CFG_IDX_W-1:0] REG_COARSE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROCS_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROCS_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PROCS_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REFINE   = 3'd6;

    typedef struct packed {
        logic [IDX_W-1:0]  fine;
        logic [IDX_W-1:0]  split;
        logic [IDX_W-1:0]  narrow;
        logic [IDX_W-1:0]  wide;
        logic [RCP_W-1:0]  rcp_narrow;
        logic [RCP_W-1:0]  rcp_wide;
        logic [NODE_W-1:0] rem;
    } axis_par_t;

    typedef struct packed {
        logic                busy;
        logic                bad;
        logic [PROCS_W-1:0]  procs_y;
        logic [PROCS_W-1:0]  procs_z;
    } setup_stat_t;

endpackage

// File: rtl/gpor_setup.sv
// ---------------------------------------------------------------------------
// gpor_setup: configuration registers and derived axis parameters
// a shared restoring divider works out block widths and reciprocals
// ---------------------------------------------------------------------------
module gpor_setup (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [gpor_pkg::CFG_IDX_W-1:0]         wr_index,
    input  logic [gpor_pkg::CFG_DATA_W-1:0]        wr_data,
    output gpor_pkg::axis_par_t [gpor_pkg::NUM_AXES-1:0] par,
    output gpor_pkg::setup_stat_t                  stat
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOAD  = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_STORE = 4'b1000
    } seq_state_t;

    localparam logic [1:0] OP_SIZE   = 2'd0;
    localparam logic [1:0] OP_RCP_N  = 2'd1;
    localparam logic [1:0] OP_RCP_W  = 2'd2;

    localparam int DIV_W = gpor_pkg::RCP_W;
    localparam logic [DIV_W-1:0] RCP_NUM = DIV_W'(1) << gpor_pkg::IDX_W;

    logic [gpor_pkg::COARSE_W-1:0] coarse_reg [gpor_pkg::NUM_AXES];
    logic [gpor_pkg::PROCS_W-1:0]  procs_reg  [gpor_pkg::NUM_AXES];
    logic [gpor_pkg::REFINE_W-1:0] refine_reg;

    gpor_pkg::axis_par_t [gpor_pkg::NUM_AXES-1:0] par_reg;

    seq_state_t        state_reg;
    logic [1:0]        axis_reg;
    logic [1:0]        op_reg;
    logic [3:0]        bit_reg;
    logic [DIV_W-1:0]  num_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [gpor_pkg::IDX_W-1:0] den_reg;

    logic [DIV_W-1:0]  rem_shift;
    logic              fits;
    logic [DIV_W-1:0]  rem_next;
    logic [DIV_W-1:0]  num_next;
    logic              bad_next;
    logic [gpor_pkg::IDX_W-1:0] narrow_calc;
    logic [gpor_pkg::IDX_W-1:0] wide_calc;
    logic [gpor_pkg::IDX_W-1:0] fine_calc;
    logic [23:0]       split_calc;
    logic [gpor_pkg::NODE_W-1:0] rem_calc;

    always_comb
    begin
        rem_shift = {rem_reg[DIV_W-2:0], num_reg[DIV_W-1]};
        fits      = rem_shift >= {1'b0, den_reg};
        rem_next  = fits ? (rem_shift - {1'b0, den_reg}) : rem_shift;
        num_next  = {num_reg[DIV_W-2:0], fits};
    end

    always_comb
    begin
        narrow_calc = gpor_pkg::IDX_W'(num_reg[gpor_pkg::COARSE_W-1:0] * refine_reg);
        rem_calc    = rem_reg[gpor_pkg::NODE_W-1:0];
        wide_calc   = narrow_calc + ((rem_reg != '0) ? gpor_pkg::IDX_W'(refine_reg)
                                                     : gpor_pkg::IDX_W'(0));
        fine_calc   = gpor_pkg::IDX_W'(coarse_reg[axis_reg] * refine_reg);
        split_calc  = 24'(par_reg[axis_reg].rem * par_reg[axis_reg].wide);
    end

    always_comb
    begin
        bad_next = (refine_reg == '0);
        for (int a = 0; a < gpor_pkg::NUM_AXES; a++)
        begin
            if (procs_reg[a] == '0 || {2'b00, procs_reg[a]} > coarse_reg[a] ||
                procs_reg[a] > gpor_pkg::PROCS_W'(gpor_pkg::MAX_PROCS_AXIS))
            begin
                bad_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < gpor_pkg::NUM_AXES; a++)
            begin
                coarse_reg[a] <= gpor_pkg::COARSE_W'(64);
                procs_reg[a]  <= gpor_pkg::PROCS_W'(1);
            end
            refine_reg <= gpor_pkg::REFINE_W'(1);
            state_reg  <= ST_LOAD;
            axis_reg   <= '0;
            op_reg     <= OP_SIZE;
            bit_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                gpor_pkg::REG_COARSE_X: coarse_reg[0] <= wr_data;
                gpor_pkg::REG_COARSE_Y: coarse_reg[1] <= wr_data;
                gpor_pkg::REG_COARSE_Z: coarse_reg[2] <= wr_data;
                gpor_pkg::REG_PROCS_X:  procs_reg[0]  <= wr_data[gpor_pkg::PROCS_W-1:0];
                gpor_pkg::REG_PROCS_Y:  procs_reg[1]  <= wr_data[gpor_pkg::PROCS_W-1:0];
                gpor_pkg::REG_PROCS_Z:  procs_reg[2]  <= wr_data[gpor_pkg::PROCS_W-1:0];
                gpor_pkg::REG_REFINE:   refine_reg    <= wr_data[gpor_pkg::REFINE_W-1:0];
                default: ;
            endcase
            // any write restarts the derivation from the first axis
            state_reg <= ST_LOAD;
            axis_reg  <= '0;
            op_reg    <= OP_SIZE;
            bit_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    bit_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    bit_reg <= bit_reg + 4'd1;
                    if (bit_reg == 4'(DIV_W - 1))
                    begin
                        state_reg <= ST_STORE;
                    end
                end
                ST_STORE:
                begin
                    if (op_reg == OP_RCP_W)
                    begin
                        op_reg <= OP_SIZE;
                        if (axis_reg == 2'(gpor_pkg::NUM_AXES - 1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= ST_LOAD;
                        end
                    end
                    else
                    begin
                        op_reg    <= op_reg + 2'd1;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_IDLE: ;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // divider datapath and derived results
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_LOAD:
            begin
                rem_reg <= '0;
                case (op_reg)
                    OP_SIZE:
                    begin
                        num_reg <= DIV_W'(coarse_reg[axis_reg]);
                        den_reg <= gpor_pkg::IDX_W'(procs_reg[axis_reg]);
                    end
                    OP_RCP_N:
                    begin
                        num_reg <= RCP_NUM;
                        den_reg <= par_reg[axis_reg].narrow;
                        par_reg[axis_reg].split <= split_calc[gpor_pkg::IDX_W-1:0];
                    end
                    default:
                    begin
                        num_reg <= RCP_NUM;
                        den_reg <= par_reg[axis_reg].wide;
                    end
                endcase
            end
            ST_DIV:
            begin
                rem_reg <= rem_next;
                num_reg <= num_next;
            end
            ST_STORE:
            begin
                case (op_reg)
                    OP_SIZE:
                    begin
                        par_reg[axis_reg].narrow <= narrow_calc;
                        par_reg[axis_reg].wide   <= wide_calc;
                        par_reg[axis_reg].rem    <= rem_calc;
                        par_reg[axis_reg].fine   <= fine_calc;
                    end
                    OP_RCP_N: par_reg[axis_reg].rcp_narrow <= num_reg;
                    default:  par_reg[axis_reg].rcp_wide   <= num_reg;
                endcase
            end
            default: ;
        endcase
    end

    assign par          = par_reg;
    assign stat.busy    = (state_reg != ST_IDLE);
    assign stat.bad     = bad_next;
    assign stat.procs_y = procs_reg[1];
    assign stat.procs_z = procs_reg[2];

endmodule

// File: rtl/gpor_axis.sv
// ---------------------------------------------------------------------------
// gpor_axis: one axis of the owner pipeline
// snaps a coordinate to the fine grid and finds the owning block by reciprocal
// ---------------------------------------------------------------------------
module gpor_axis (
    input  logic                                clk,
    input  logic [gpor_pkg::AXIS_STAGES-1:0]    en,
    input  logic [gpor_pkg::COORD_W-1:0]        coord,
    input  gpor_pkg::axis_par_t                 par,
    output logic [gpor_pkg::NODE_W-1:0]         node
);

    localparam int IW = gpor_pkg::IDX_W;
    localparam int FB = gpor_pkg::FRAC_BITS;
    localparam logic [FB-1:0] HALF = FB'(1) << (FB - 1);

    logic [FB-1:0]                  coord_reg;
    logic [gpor_pkg::PROD_W-1:0]    prod_reg;
    logic [IW-1:0]                  idx_reg;
    logic [IW-1:0]                  t3_reg, d3_reg;
    logic [gpor_pkg::RCP_W-1:0]     rcp3_reg;
    logic [gpor_pkg::NODE_W-1:0]    base3_reg;
    logic [IW-1:0]                  t4_reg, d4_reg, qe4_reg;
    logic [gpor_pkg::NODE_W-1:0]    base4_reg;
    logic [IW-1:0]                  t5_reg, d5_reg, qe5_reg, qd5_reg;
    logic [gpor_pkg::NODE_W-1:0]    base5_reg;
    logic [gpor_pkg::NODE_W-1:0]    node_reg;

    logic [IW:0]                    snap_sum;
    logic [IW-1:0]                  idx_next;
    logic                           lt_split;
    logic [2*IW+1:0]                qe_prod;
    logic [2*IW-1:0]                qd_prod;
    logic [IW-1:0]                  left;
    logic [gpor_pkg::NODE_W-1:0]    node_next;

    always_comb
    begin
        // exact half rounds down
        snap_sum = {1'b0, prod_reg[gpor_pkg::PROD_W-1:FB]} +
                   (IW+1)'(prod_reg[FB-1:0] > HALF);
        idx_next = (snap_sum >= {1'b0, par.fine}) ? IW'(snap_sum - {1'b0, par.fine})
                                                  : snap_sum[IW-1:0];
        lt_split = idx_reg < par.split;
        qe_prod  = t3_reg * rcp3_reg;
        qd_prod  = qe4_reg * d4_reg;
        left     = t5_reg - qd5_reg;
        node_next = base5_reg + qe5_reg[gpor_pkg::NODE_W-1:0] +
                    gpor_pkg::NODE_W'(left >= d5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            coord_reg <= coord[FB-1:0];
        end
        if (en[1])
        begin
            prod_reg <= coord_reg * par.fine;
        end
        if (en[2])
        begin
            idx_reg <= idx_next;
        end
        if (en[3])
        begin
            t3_reg    <= lt_split ? idx_reg : (idx_reg - par.split);
            d3_reg    <= lt_split ? par.wide : par.narrow;
            rcp3_reg  <= lt_split ? par.rcp_wide : par.rcp_narrow;
            base3_reg <= lt_split ? '0 : par.rem;
        end
        if (en[4])
        begin
            // estimate is the quotient or one below it
            qe4_reg   <= qe_prod[2*IW-1:IW];
            t4_reg    <= t3_reg;
            d4_reg    <= d3_reg;
            base4_reg <= base3_reg;
        end
        if (en[5])
        begin
            qd5_reg   <= qd_prod[IW-1:0];
            qe5_reg   <= qe4_reg;
            t5_reg    <= t4_reg;
            d5_reg    <= d4_reg;
            base5_reg <= base4_reg;
        end
        if (en[6])
        begin
            node_reg <= node_next;
        end
    end

    assign node = node_reg;

endmodule

// File: rtl/grid_point_owner_rank.sv
// ---------------------------------------------------------------------------
// grid_point_owner_rank: owning processor of a 3-d grid position
// snaps three Q0.24 coordinates to the fine grid and returns node and rank
// ---------------------------------------------------------------------------
// Fully pipelined: one position per cycle while the result side is ready and no
// setup runs, through the per-axis multiply chain and the rank multiply-adds.
// After reset and after every configuration write a shared 16-bit divider
// works out block widths and reciprocals for the three axes in nine divisions,
// and s_tready stays low until they are done.
module grid_point_owner_rank (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // coord_x, coord_y, coord_z
    input  logic [71:0]                         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // owner_rank, node_x, node_y, node_z, bad_setup, zero pad
    output logic [55:0]                         m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gpor_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gpor_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NS = gpor_pkg::NUM_STAGES;
    localparam int AS = gpor_pkg::AXIS_STAGES;
    localparam int NW = gpor_pkg::NODE_W;
    localparam int CW = gpor_pkg::COORD_W;

    gpor_pkg::axis_par_t [gpor_pkg::NUM_AXES-1:0] par;
    gpor_pkg::setup_stat_t                        stat;

    logic [NS-1:0]   valid_reg;
    logic [NS-1:0]   en;
    logic [NW-1:0]   node [gpor_pkg::NUM_AXES];

    logic [16:0]     part_reg;
    logic [NW-1:0]   nx8_reg, ny8_reg, nz8_reg;
    logic [gpor_pkg::RANK_W-1:0] rank_reg;
    logic [NW-1:0]   nx9_reg, ny9_reg, nz9_reg;
    logic [55:0]     out_reg;
    logic [25:0]     rank_prod;

    assign cfg_ready = 1'b1;

    gpor_setup u_setup (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .par      (par),
        .stat     (stat)
    );

    for (genvar a = 0; a < gpor_pkg::NUM_AXES; a++)
    begin : g_axis
        gpor_axis u_axis (
            .clk   (clk),
            .en    (en[AS-1:0]),
            .coord (s_tdata[a*CW +: CW]),
            .par   (par[a]),
            .node  (node[a])
        );
    end

    // a stage moves when it is empty or the next one moves
    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0] && !stat.busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= s_tvalid && s_tready;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign rank_prod = part_reg * stat.procs_z;

    always_ff @(posedge clk)
    begin
        if (en[AS])
        begin
            part_reg <= 17'(node[0] * stat.procs_y) + 17'(node[1]);
            nx8_reg  <= node[0];
            ny8_reg  <= node[1];
            nz8_reg  <= node[2];
        end
        if (en[AS+1])
        begin
            rank_reg <= rank_prod[gpor_pkg::RANK_W-1:0] + gpor_pkg::RANK_W'(nz8_reg);
            nx9_reg  <= nx8_reg;
            ny9_reg  <= ny8_reg;
            nz9_reg  <= nz8_reg;
        end
        if (en[AS+2])
        begin
            if (stat.bad)
            begin
                out_reg <= {7'd0, 1'b1, 48'd0};
            end
            else
            begin
                out_reg <= {7'd0, 1'b0, nz9_reg, ny9_reg, nx9_reg, rank_reg};
            end
        end
    end

    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = out_reg;

endmodule

// File: test/grid_point_owner_rank_tb.sv
// ---------------------------------------------------------------------------
// grid_point_owner_rank_tb: self-checking bench for the grid point owner block
// streams coordinates under several grid setups and compares node and rank
// against a behavioural predictor, with random idling on both stream sides
// ---------------------------------------------------------------------------
module grid_point_owner_rank_tb;

    typedef struct packed {
        logic                         bad_setup;
        logic [gpor_pkg::NODE_W-1:0]  node_z;
        logic [gpor_pkg::NODE_W-1:0]  node_y;
        logic [gpor_pkg::NODE_W-1:0]  node_x;
        logic [gpor_pkg::RANK_W-1:0]  owner_rank;
    } owner_t;

    class owner_scoreboard;
        int unsigned coarse [gpor_pkg::NUM_AXES];
        int unsigned procs [gpor_pkg::NUM_AXES];
        int unsigned refine;
        owner_t      pending [$];
        int          mismatches;

        function new();
            for (int a = 0; a < gpor_pkg::NUM_AXES; a++)
            begin
                coarse[a] = 64;
                procs[a]  = 1;
            end
            refine     = 1;
            mismatches = 0;
        endfunction

        function void write_reg(logic [gpor_pkg::CFG_IDX_W-1:0] idx,
                                logic [gpor_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                gpor_pkg::REG_COARSE_X: coarse[0] = 32'(val);
                gpor_pkg::REG_COARSE_Y: coarse[1] = 32'(val);
                gpor_pkg::REG_COARSE_Z: coarse[2] = 32'(val);
                gpor_pkg::REG_PROCS_X:  procs[0]  = 32'(val[gpor_pkg::PROCS_W-1:0]);
                gpor_pkg::REG_PROCS_Y:  procs[1]  = 32'(val[gpor_pkg::PROCS_W-1:0]);
                gpor_pkg::REG_PROCS_Z:  procs[2]  = 32'(val[gpor_pkg::PROCS_W-1:0]);
                gpor_pkg::REG_REFINE:   refine    = 32'(val[gpor_pkg::REFINE_W-1:0]);
                default: ;
            endcase
        endfunction

        function int unsigned snap_node(int a, logic [gpor_pkg::COORD_W-1:0] c);
            longint unsigned fine, prod, idx, narrow, rem, wide, split;
            fine = coarse[a] * refine;
            prod = longint'(c) * fine;
            idx  = prod >> gpor_pkg::FRAC_BITS;
            // exact half rounds down
            if ((prod & ((64'd1 << gpor_pkg::FRAC_BITS) - 1)) >
                (64'd1 << (gpor_pkg::FRAC_BITS - 1)))
                idx++;
            if (idx >= fine)
                idx -= fine;
            narrow = refine * (coarse[a] / procs[a]);
            rem    = coarse[a] % procs[a];
            wide   = narrow + (rem != 0 ? refine : 0);
            split  = rem * wide;
            if (idx < split)
                return 32'(idx / wide);
            return 32'(rem + (idx - split) / narrow);
        endfunction

        function void note_position(logic [71:0] pos);
            owner_t      e;
            int unsigned n [gpor_pkg::NUM_AXES];
            logic        bad;
            longint unsigned r;
            bad = (refine == 0);
            for (int a = 0; a < gpor_pkg::NUM_AXES; a++)
                if (procs[a] == 0 || procs[a] > coarse[a] ||
                    procs[a] > gpor_pkg::MAX_PROCS_AXIS)
                    bad = 1'b1;
            e = '0;
            e.bad_setup = bad;
            if (!bad)
            begin
                for (int a = 0; a < gpor_pkg::NUM_AXES; a++)
                    n[a] = snap_node(a, pos[a*gpor_pkg::COORD_W +: gpor_pkg::COORD_W]);
                r = longint'(n[0]) * procs[1] * procs[2] + longint'(n[1]) * procs[2] + n[2];
                e.owner_rank = r[gpor_pkg::RANK_W-1:0];
                e.node_x     = n[0][gpor_pkg::NODE_W-1:0];
                e.node_y     = n[1][gpor_pkg::NODE_W-1:0];
                e.node_z     = n[2][gpor_pkg::NODE_W-1:0];
            end
            pending.push_back(e);
        endfunction

        function void check_owner(logic [55:0] data);
            owner_t got, e;
            got = data[$bits(owner_t)-1:0];
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: rank %0d/%0d nodes %0d,%0d,%0d/%0d,%0d,%0d bad %0d/%0d",
                        e.owner_rank, got.owner_rank, e.node_x, e.node_y, e.node_z,
                        got.node_x, got.node_y, got.node_z, e.bad_setup, got.bad_setup);
            end
        endfunction
    endclass

    logic                                 clk;
    logic                                 rst_n;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [71:0]                          s_tdata;
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [55:0]                          m_tdata;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [gpor_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [gpor_pkg::CFG_DATA_W-1:0]      cfg_data;

    owner_scoreboard owners;
    bit              quiet_tail;

    grid_point_owner_rank i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // drops cfg_valid after the write is taken, so writes never run back to back
    task automatic write_reg(logic [gpor_pkg::CFG_IDX_W-1:0] idx,
                             logic [gpor_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        owners.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_grid(int cx, int cy, int cz, int px, int py, int pz, int rf);
        write_reg(gpor_pkg::REG_COARSE_X, gpor_pkg::CFG_DATA_W'(cx));
        write_reg(gpor_pkg::REG_COARSE_Y, gpor_pkg::CFG_DATA_W'(cy));
        write_reg(gpor_pkg::REG_COARSE_Z, gpor_pkg::CFG_DATA_W'(cz));
        write_reg(gpor_pkg::REG_PROCS_X, gpor_pkg::CFG_DATA_W'(px));
        write_reg(gpor_pkg::REG_PROCS_Y, gpor_pkg::CFG_DATA_W'(py));
        write_reg(gpor_pkg::REG_PROCS_Z, gpor_pkg::CFG_DATA_W'(pz));
        write_reg(gpor_pkg::REG_REFINE, gpor_pkg::CFG_DATA_W'(rf));
    endtask

    // s_tvalid stays high on return so positions can follow back to back
    task automatic send_position(logic [23:0] x, logic [23:0] y, logic [23:0] z);
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tdata  <= {z, y, x};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        owners.note_position({z, y, x});
        @(negedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (owners.pending.size() != 0)
            @(negedge clk);
        repeat (gpor_pkg::NUM_STAGES + 4) @(negedge clk);
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'h0;
            1: return 24'hFFFFFF;
            2: return 24'(24'h800000 + $urandom_range(0, 2) - 1);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_positions(int count);
        for (int i = 0; i < count; i++)
            send_position(rand_coord(), rand_coord(), rand_coord());
    endtask

    // result side: random stall bursts
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            owners.check_owner(m_tdata);

    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        owners     = new();
        quiet_tail = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // reset setup: corners, the rounding midpoint either side, wrap at the top
        send_position(24'h0, 24'h0, 24'h0);
        send_position(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_position(24'h020000, 24'h020001, 24'h01FFFF);
        send_position(24'h800000, 24'h7FFFFF, 24'h555555);
        drain();

        // uneven split with some wide blocks
        set_grid(10, 7, 1024, 3, 7, 256, 8);
        send_position(24'h0, 24'hFFFFFF, 24'h800000);
        send_position(24'hAAAAAA, 24'h123456, 24'hFFFFFF);
        random_positions(100);
        // sender holds off until every result is back
        drain();

        // most processors, largest refinement, on a 1024-point coarse grid
        set_grid(1024, 1024, 1024, 256, 256, 256, 15);
        send_position(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        random_positions(60);
        drain();

        // bad setups: procs above coarse or 256, procs zero, refine zero
        set_grid(1, 1, 1, 2, 1, 1, 1);
        send_position(24'h123456, 24'h654321, 24'hABCDEF);
        drain();
        write_reg(gpor_pkg::REG_PROCS_X, gpor_pkg::CFG_DATA_W'(0));
        send_position(24'hFFFFFF, 24'h0, 24'h0);
        drain();
        write_reg(gpor_pkg::REG_PROCS_X, gpor_pkg::CFG_DATA_W'(1));
        write_reg(gpor_pkg::REG_REFINE, gpor_pkg::CFG_DATA_W'(0));
        send_position(24'h800001, 24'h800000, 24'h7FFFFF);
        drain();
        write_reg(3'd7, 11'h7FF);
        send_position(24'h1, 24'h2, 24'h3);
        drain();
        set_grid(300, 300, 300, 257, 2, 300, 1);
        send_position(24'h400000, 24'h400000, 24'h400000);
        drain();

        // smallest usable grid
        set_grid(1, 1, 1, 1, 1, 1, 1);
        random_positions(30);
        drain();

        for (int k = 0; k < 3; k++)
        begin
            set_grid($urandom_range(1, 2047), $urandom_range(1, 64), $urandom_range(1, 300),
                $urandom_range(1, 16), $urandom_range(1, 64), $urandom_range(1, 256),
                $urandom_range(1, 15));
            random_positions(70);
            drain();
        end

        set_grid(97, 200, 33, 13, 200, 5, 3);
        random_positions(40);
        quiet_tail = 1;
        random_positions(40);
        drain();

        if (owners.mismatches == 0 && owners.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
